/* src/point_range_sphere_mask_core_defines.svh */
// Assertion macros shared by the point range / sphere mask RTL.
`ifndef POINT_RANGE_SPHERE_MASK_CORE_DEFINES_SVH
`define POINT_RANGE_SPHERE_MASK_CORE_DEFINES_SVH

// Clocked check, ignored while reset is asserted.
`define PRSM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define PRSM_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/prsm_pkg.sv */
// Shared constants, types and helper functions for the point range / sphere mask block.
package prsm_pkg;

    localparam int COORD_BITS = 32;
    localparam int RAD_W      = COORD_BITS - 1;
    localparam int MAG_W      = COORD_BITS + 1;
    localparam int SEG_SQ_W   = 2 * MAG_W;
    localparam int RNG_SQ_W   = 2 * COORD_BITS;
    localparam int RAD_SQ_W   = 2 * RAD_W;
    localparam int SEG_SUM_W  = SEG_SQ_W + 2;
    localparam int RNG_SUM_W  = RNG_SQ_W + 2;

    localparam int DATA_W     = (COORD_BITS > 32) ? 64 : 32;
    localparam int ADDR_LSB   = (DATA_W == 64) ? 3 : 2;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = ADDR_LSB + IDX_W;

    typedef logic [IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_CENTER_X = 3'd0;
    localparam t_reg_idx REG_CENTER_Y = 3'd1;
    localparam t_reg_idx REG_CENTER_Z = 3'd2;
    localparam t_reg_idx REG_RADIUS   = 3'd3;
    localparam t_reg_idx REG_MAX_RNG  = 3'd4;

    localparam logic [7:0] LABEL_BG  = 8'd254;
    localparam logic [7:0] LABEL_BAD = 8'd255;
    localparam logic [7:0] ALPHA_ON  = 8'd255;
    localparam logic [7:0] ALPHA_OFF = 8'd0;

    // pass-through payload carried down the pipe
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
        logic [7:0]                   label;
        logic                         finite;
    } t_pix;

    // magnitudes feeding the squaring stage
    typedef struct packed {
        logic [2:0][MAG_W-1:0]      seg;
        logic [2:0][COORD_BITS-1:0] rng;
    } t_mags;

    // registered squares and thresholds
    typedef struct packed {
        logic [2:0][SEG_SQ_W-1:0] seg;
        logic [2:0][RNG_SQ_W-1:0] rng;
        logic [RAD_SQ_W-1:0]      rad2;
        logic [RAD_SQ_W-1:0]      rmax2;
    } t_sqs;

    // |a - b|, exact in one extra bit
    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [MAG_W-1:0] d;
        d = MAG_W'(a) - MAG_W'(b);
        return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

    // |a|; the most negative value maps to its unsigned magnitude
    function automatic logic [COORD_BITS-1:0] mag_of(
        input logic signed [COORD_BITS-1:0] a
    );
        logic signed [MAG_W-1:0] e;
        logic signed [MAG_W-1:0] n;
        e = MAG_W'(a);
        n = -e;
        return a[COORD_BITS-1] ? n[COORD_BITS-1:0] : e[COORD_BITS-1:0];
    endfunction

endpackage

/* src/prsm_square_stage.sv */
// Registered squaring stage: six distance terms plus the two squared thresholds.
module prsm_square_stage
    import prsm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  t_mags            i_mags,
    input  logic [RAD_W-1:0] i_radius,
    input  logic [RAD_W-1:0] i_max_range,
    output t_sqs             o_sqs
);

    t_sqs r_sqs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sqs.seg[k] <= SEG_SQ_W'(i_mags.seg[k]) * SEG_SQ_W'(i_mags.seg[k]);
                r_sqs.rng[k] <= RNG_SQ_W'(i_mags.rng[k]) * RNG_SQ_W'(i_mags.rng[k]);
            end
            // thresholds are to change only while idle, which the block does not enforce; squared alongside the data
            r_sqs.rad2  <= RAD_SQ_W'(i_radius) * RAD_SQ_W'(i_radius);
            r_sqs.rmax2 <= RAD_SQ_W'(i_max_range) * RAD_SQ_W'(i_max_range);
        end
    end

    assign o_sqs = r_sqs;

endmodule

/* src/point_range_sphere_mask_core.sv */
// Top level of the point range gate and sphere segment mask.
// A transaction passes through stage 1, the squaring stage and the output register, where its verdict shows.
// Throughput: one transaction per cycle while the output is not stalled; each of the three stages holds one point.
// Rate is set by the squaring stage (one set of eight multipliers, fully pipelined).
// Reset (synchronous, active low) empties the pipe and loads center 0, radius 0,
// max range all ones.
`include "point_range_sphere_mask_core_defines.svh"

module point_range_sphere_mask_core
    import prsm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready,

    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [7:0]                   i_red,
    input  logic [7:0]                   i_green,
    input  logic [7:0]                   i_blue,
    input  logic [7:0]                   i_label_in,
    input  logic                         i_coords_finite,

    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic signed [COORD_BITS-1:0] o_out_z,
    output logic [7:0]                   o_out_red,
    output logic [7:0]                   o_out_green,
    output logic [7:0]                   o_out_blue,
    output logic [7:0]                   o_filtered_label,
    output logic                         o_in_full_cloud,
    output logic                         o_in_seg_cloud,
    output logic [7:0]                   o_alpha_out
);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] r_cx, r_cy, r_cz;
    logic [RAD_W-1:0]             r_radius, r_max_range;
    t_reg_idx                     cfg_idx;
    logic                         cfg_wr;

    assign cfg_idx = paddr[ADDR_LSB +: IDX_W];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx        <= '0;
            r_cy        <= '0;
            r_cz        <= '0;
            r_radius    <= '0;
            r_max_range <= '1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CENTER_X: r_cx        <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Y: r_cy        <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Z: r_cz        <= pwdata[COORD_BITS-1:0];
                REG_RADIUS:   r_radius    <= pwdata[RAD_W-1:0];
                REG_MAX_RNG:  r_max_range <= pwdata[RAD_W-1:0];
                default: ;    // unmapped: write dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_CENTER_X: prdata = DATA_W'(unsigned'(r_cx));
            REG_CENTER_Y: prdata = DATA_W'(unsigned'(r_cy));
            REG_CENTER_Z: prdata = DATA_W'(unsigned'(r_cz));
            REG_RADIUS:   prdata = DATA_W'(r_radius);
            REG_MAX_RNG:  prdata = DATA_W'(r_max_range);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipe control: a stage loads whenever it is empty or the stage
    // after it moves on, so bubbles collapse and back pressure stops
    // only the stages that are full.
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic out_can, s2_can, s1_can, in_accept;

    assign out_can    = !r_out_valid || !i_out_stall;
    assign s2_can     = !r_s2_valid || out_can;
    assign s1_can     = !r_s1_valid || s2_can;
    assign o_in_stall = !s1_can;
    assign in_accept  = i_in_valid && s1_can;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_can)  r_s1_valid  <= i_in_valid;
            if (s2_can)  r_s2_valid  <= r_s1_valid;
            if (out_can) r_out_valid <= r_s2_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the transaction with its magnitudes, both to the
    // camera origin and to the sphere center.
    // ------------------------------------------------------------------
    t_pix  r_s1_pix, r_s2_pix;
    t_mags r_s1_mags;

    always_ff @(posedge i_clk) begin
        if (s1_can) begin
            r_s1_pix.x      <= i_pos_x;
            r_s1_pix.y      <= i_pos_y;
            r_s1_pix.z      <= i_pos_z;
            r_s1_pix.red    <= i_red;
            r_s1_pix.green  <= i_green;
            r_s1_pix.blue   <= i_blue;
            r_s1_pix.label  <= i_label_in;
            r_s1_pix.finite <= i_coords_finite;
            r_s1_mags.rng[0] <= mag_of(i_pos_x);
            r_s1_mags.rng[1] <= mag_of(i_pos_y);
            r_s1_mags.rng[2] <= mag_of(i_pos_z);
            r_s1_mags.seg[0] <= abs_diff(i_pos_x, r_cx);
            r_s1_mags.seg[1] <= abs_diff(i_pos_y, r_cy);
            r_s1_mags.seg[2] <= abs_diff(i_pos_z, r_cz);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares (exact, no rounding)
    // ------------------------------------------------------------------
    t_sqs s2_sqs;

    prsm_square_stage u_square (
        .i_clk       (i_clk),
        .i_en        (s2_can),
        .i_mags      (r_s1_mags),
        .i_radius    (r_radius),
        .i_max_range (r_max_range),
        .o_sqs       (s2_sqs)
    );

    always_ff @(posedge i_clk) begin
        if (s2_can) r_s2_pix <= r_s1_pix;
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of squares and inclusive compares -> verdict
    // ------------------------------------------------------------------
    logic [RNG_SUM_W-1:0] rng_sum;
    logic [SEG_SUM_W-1:0] seg_sum;
    logic                 n_full, n_seg;

    assign rng_sum = RNG_SUM_W'(s2_sqs.rng[0]) + RNG_SUM_W'(s2_sqs.rng[1])
                   + RNG_SUM_W'(s2_sqs.rng[2]);
    assign seg_sum = SEG_SUM_W'(s2_sqs.seg[0]) + SEG_SUM_W'(s2_sqs.seg[1])
                   + SEG_SUM_W'(s2_sqs.seg[2]);

    // background or non-finite drops the point before any range test
    assign n_full = (r_s2_pix.label != LABEL_BG) && r_s2_pix.finite
                 && (rng_sum <= RNG_SUM_W'(s2_sqs.rmax2));
    assign n_seg  = n_full && (r_s2_pix.label != LABEL_BAD)
                 && (seg_sum <= SEG_SUM_W'(s2_sqs.rad2));

    t_pix       r_out_pix;
    logic       r_out_full, r_out_seg;
    logic [7:0] r_out_label, r_out_alpha;

    always_ff @(posedge i_clk) begin
        if (out_can) begin
            r_out_pix   <= r_s2_pix;
            r_out_full  <= n_full;
            r_out_seg   <= n_seg;
            r_out_label <= n_seg ? r_s2_pix.label : LABEL_BAD;
            r_out_alpha <= n_seg ? ALPHA_ON : ALPHA_OFF;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_x          = r_out_pix.x;
    assign o_out_y          = r_out_pix.y;
    assign o_out_z          = r_out_pix.z;
    assign o_out_red        = r_out_pix.red;
    assign o_out_green      = r_out_pix.green;
    assign o_out_blue       = r_out_pix.blue;
    assign o_filtered_label = r_out_label;
    assign o_in_full_cloud  = r_out_full;
    assign o_in_seg_cloud   = r_out_seg;
    assign o_alpha_out      = r_out_alpha;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PRSM_CHECK(a_seg_in_full, o_out_valid && o_in_seg_cloud |-> o_in_full_cloud, "segment point outside full cloud")
    `PRSM_CHECK(a_seg_label_ok, o_out_valid && o_in_seg_cloud |-> (o_filtered_label != LABEL_BG && o_filtered_label != LABEL_BAD), "segment point with reserved label")
    `PRSM_CHECK(a_accept_fills_s1, i_in_valid && !o_in_stall |=> r_s1_valid, "accepted transaction lost at stage 1")
    `PRSM_CHECK(a_full_pipe_stalls, r_out_valid && i_out_stall && r_s2_valid && r_s1_valid |-> o_in_stall, "full stalled pipe still accepting")
    `PRSM_CHECK_ALWAYS(a_reset_empties, !i_rst_n |=> !r_s1_valid && !r_s2_valid && !r_out_valid, "pipe not empty after reset")

endmodule
